/* rtl/rpgw_pkg.sv */
package rpgw_pkg;

  // Pixels in one group and the depth of the queue between front and back.
  localparam int unsigned GROUP_PIXELS = 8;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [12:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [15:0] RST_LINE_STRIDE  = 16'd2560;
  localparam logic [31:0] RST_BASE_ADDRESS = 32'd0;

  // Bytes per pixel word.
  localparam logic [31:0] PIXEL_BYTES = 32'd4;

  // Rotation codes; the unused code behaves as no rotation.
  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_CCW  = 2'd1,
    ROT_CW   = 2'd2
  } rot_e;

  // Live configuration.
  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [15:0] line_stride;
    logic [31:0] base_address;
    logic [1:0]  rotation_mode;
  } cfg_t;

  // One input beat after unpacking.
  typedef struct packed {
    logic        command;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  bit_mask;
    logic [3:0]  pixel_count;
    logic [31:0] pixel_color;
  } item_t;

  // One queued job: address of the group's first pixel and the pixels to write.
  // Bit i of pix_en enables pixel pixel_x + i.
  typedef struct packed {
    logic [31:0]             addr0;
    logic [GROUP_PIXELS-1:0] pix_en;
    logic [31:0]             color;
    logic                    is_xor;
  } job_t;

  // Queue status seen by the front, the back and the checks.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

/* rtl/rpgw_front.sv */
module rpgw_front import rpgw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  item_t   in_item_i,
  input  q_stat_t q_stat_i,
  output logic    q_push_o,
  output job_t    q_entry_o
);

  logic                    s1_valid_q, s1_valid_d;
  logic [GROUP_PIXELS-1:0] s1_en_q, en_d;
  logic [12:0]             s1_row_q, row_d;
  logic [12:0]             s1_col_q, col_d;
  logic [31:0]             s1_color_q;
  logic                    s1_xor_q;
  logic [28:0]             row_bytes;
  logic                    accept;

  // Classify each pixel of the group: enabled, within count, inside the frame.
  always_comb begin
    for (int i = 0; i < GROUP_PIXELS; i++) begin
      en_d[i] = in_item_i.bit_mask[3'(7 - i)]
             && (4'(i) < in_item_i.pixel_count)
             && ((13'(in_item_i.pixel_x) + 13'(i)) < cfg_i.frame_width)
             && (13'(in_item_i.pixel_y) < cfg_i.frame_height);
    end
  end

  // Physical row and column of the group's first pixel. When any pixel is
  // written, the subtractions cannot go below zero.
  always_comb begin
    case (cfg_i.rotation_mode)
      ROT_CCW: begin
        col_d = 13'(in_item_i.pixel_y);
        row_d = cfg_i.frame_width - 13'd1 - 13'(in_item_i.pixel_x);
      end
      ROT_CW: begin
        col_d = cfg_i.frame_height - 13'd1 - 13'(in_item_i.pixel_y);
        row_d = 13'(in_item_i.pixel_x);
      end
      default: begin
        col_d = 13'(in_item_i.pixel_x);
        row_d = 13'(in_item_i.pixel_y);
      end
    endcase
  end

  // A held group moves on when the queue has room, or drops if nothing is enabled.
  assign in_ready_o = !s1_valid_q || (s1_en_q == '0) || !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign s1_valid_d = accept ? 1'b1 : (in_ready_o ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_en_q    <= en_d;
      s1_row_q   <= row_d;
      s1_col_q   <= col_d;
      s1_color_q <= in_item_i.pixel_color;
      s1_xor_q   <= in_item_i.command;
    end
  end

  // Start address: base + row * stride + column * 4, modulo 2^32.
  assign row_bytes = 29'(s1_row_q) * 29'(cfg_i.line_stride);

  assign q_push_o         = s1_valid_q && (s1_en_q != '0) && !q_stat_i.full;
  assign q_entry_o.addr0  = cfg_i.base_address + 32'(row_bytes) + {17'b0, s1_col_q, 2'b00};
  assign q_entry_o.pix_en = s1_en_q;
  assign q_entry_o.color  = s1_color_q;
  assign q_entry_o.is_xor = s1_xor_q;

endmodule

/* rtl/rpgw_fifo.sv */
module rpgw_fifo import rpgw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    push_data_i,
  input  logic    pop_i,
  output job_t    head_o,
  output q_stat_t stat_o
);

  job_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] cnt_q;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
    ptr_next = (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_o       = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/rpgw_back.sv */
module rpgw_back import rpgw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  job_t        head_i,
  input  q_stat_t     q_stat_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_address_o,
  output logic [31:0] out_data_o,
  output logic        out_xor_o,
  output logic        out_last_o
);

  logic [GROUP_PIXELS-1:0] done_q, done_d;
  logic [GROUP_PIXELS-1:0] remain, sel_1h;
  logic [2:0]              sel;
  logic                    is_last;
  logic                    issue;
  logic [31:0]             delta, step, addr;
  logic                    out_valid_q;
  logic [31:0]             out_address_q, out_data_q;
  logic                    out_xor_q, out_last_q;

  // Lowest pending pixel of the head job goes first (ascending x).
  assign remain = head_i.pix_en & ~done_q;
  always_comb begin
    sel = '0;
    for (int i = GROUP_PIXELS - 1; i >= 0; i--) begin
      if (remain[i]) begin
        sel = 3'(i);
      end
    end
  end
  assign sel_1h  = GROUP_PIXELS'(1) << sel;
  assign is_last = ((remain & ~sel_1h) == '0);

  // Address step from one pixel to the next along x.
  always_comb begin
    case (cfg_i.rotation_mode)
      ROT_CCW: delta = 32'd0 - {16'b0, cfg_i.line_stride};
      ROT_CW:  delta = {16'b0, cfg_i.line_stride};
      default: delta = PIXEL_BYTES;
    endcase
  end

  // Offset of pixel sel as a shift-and-add over the three index bits.
  assign step = (sel[0] ? delta : 32'd0)
              + (sel[1] ? {delta[30:0], 1'b0} : 32'd0)
              + (sel[2] ? {delta[29:0], 2'b00} : 32'd0);
  assign addr = head_i.addr0 + step;

  // One write leaves whenever the queue holds a job and the output register is free or being taken.
  assign issue   = !q_stat_i.empty && (!out_valid_q || out_ready_i);
  assign q_pop_o = issue && is_last;
  assign done_d  = issue ? (is_last ? '0 : (done_q | sel_1h)) : done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_address_q <= addr;
      out_data_q    <= head_i.color;
      out_xor_q     <= head_i.is_xor;
      out_last_q    <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_address_o = out_address_q;
  assign out_data_o    = out_data_q;
  assign out_xor_o     = out_xor_q;
  assign out_last_o    = out_last_q;

endmodule

/* rtl/rotated_pixel_group_writer.sv */
// Channel   Dir  Beat contents
// s_axis    in   one pixel group: start x/y, mask, count, color; tuser = XOR command
// m_axis    out  one pixel write: address and color; tuser = XOR, tlast = final write
// cfg       in   register write: index and data, taken on every enabled edge
//
// Each input beat is accepted into the front stage; the back end then sends one write
// per cycle while the output is ready, one per pixel written (up to 8), as there is a single
// output port; a group with no writes is dropped in the front stage without queueing.
// An accepted group is held in the front stage register until the queue has room; its
// first write leaves from the output register. Front and back are parted by a two-entry
// queue, so input keeps flowing while output is stalled, until the queue fills.
// Reset clears control state only; registers take their documented defaults.
module rotated_pixel_group_writer import rpgw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [11:0] pixel_x, [23:12] pixel_y, [31:24] bit_mask, [35:32] pixel_count,
  // [67:36] pixel_color, [71:68] zero
  input  logic [71:0]           s_axis_tdata,
  // [0] command
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] write_address, [63:32] write_data
  output logic [63:0]           m_axis_tdata,
  // [0] is_xor
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t        cfg_q;
  item_t       in_item;
  job_t        q_entry, q_head;
  q_stat_t     q_stat;
  logic        q_push, q_pop;
  logic [31:0] out_address, out_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= RST_FRAME_WIDTH;
      cfg_q.frame_height  <= RST_FRAME_HEIGHT;
      cfg_q.line_stride   <= RST_LINE_STRIDE;
      cfg_q.base_address  <= RST_BASE_ADDRESS;
      cfg_q.rotation_mode <= ROT_NONE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  cfg_q.frame_width   <= cfg_data_i[12:0];
        CFG_FRAME_HEIGHT: cfg_q.frame_height  <= cfg_data_i[12:0];
        CFG_LINE_STRIDE:  cfg_q.line_stride   <= cfg_data_i[15:0];
        CFG_BASE_ADDRESS: cfg_q.base_address  <= cfg_data_i[31:0];
        CFG_ROTATION:     cfg_q.rotation_mode <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input beat.
  assign in_item.command     = s_axis_tuser;
  assign in_item.pixel_x     = s_axis_tdata[11:0];
  assign in_item.pixel_y     = s_axis_tdata[23:12];
  assign in_item.bit_mask    = s_axis_tdata[31:24];
  assign in_item.pixel_count = s_axis_tdata[35:32];
  assign in_item.pixel_color = s_axis_tdata[67:36];

  rpgw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .q_stat_i   (q_stat),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  rpgw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_entry),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  rpgw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (q_head),
    .q_stat_i      (q_stat),
    .q_pop_o       (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_address_o (out_address),
    .out_data_o    (out_data),
    .out_xor_o     (m_axis_tuser),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {out_data, out_address};

`ifndef SYNTH
  // The front never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_stat.full)
    else $error("queue push while full");

  // The back never retires a job from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  // While a write that is not the group's final one waits, its job is still queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !q_stat.empty)
    else $error("job retired before its final write");
`endif

endmodule
